/* rtl/sci_pkg.sv */
`default_nettype none

package sci_pkg;

  // Table geometry and fixed-point format
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FRAC_BITS   = 16;

  // Field widths
  localparam int INDEX_W     = 10;
  localparam int POS_W       = 32;
  localparam int DER_W       = 48;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 11;
  localparam int RATE_W      = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd2;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd50;

  // Item commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_COUNT = 1'b0,
    CFG_SAMPLE_RATE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [INDEX_W-1:0]        sample_index;
    logic signed [POS_W-1:0]   sample_value;
    logic                      last_sample;
    logic [TIME_W-1:0]         query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   value;
    logic signed [DER_W-1:0]   slope;
    logic signed [DER_W-1:0]   acceleration;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/sampled_curve_interpolator_unit.sv */
// Sampled curve interpolator: stores up to 1024 Q16.16 samples of a uniformly
// sampled curve and plays them back by linear interpolation.
// Input channel (in_valid / in_stall / in_data): a load item writes one sample;
// a load with last_sample set then runs a derivative pass that builds the
// slope table and then the acceleration table, taking each entry through read
// low, read high, subtract, multiply and write; in_stall is high throughout.
// An evaluate item runs multiply, index, two reads and a capture, then subtract,
// multiply and add for each of three lanes; the block takes no new item until
// its result has moved to out_data. All work runs through one shared 50x17
// multiplier and one read port per table, stepped by a small sequencer.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// sample_count, index 1 is sample_rate; cfg_ready is always high. Write only
// while the block is idle.
// A finished result sits in an output register while out_stall is high; a
// further result waits in the sequencer's last step, with in_stall high, until
// that register frees up. Reset (rst_n low, synchronous) returns to idle, drops
// any pending result and restores sample_count 2 and sample_rate 50; table
// contents are undefined until loaded.
`default_nettype none

module sampled_curve_interpolator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sci_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sci_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sci_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sci_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W  = sci_pkg::ADDR_W;
  localparam int FRAC    = sci_pkg::FRAC_BITS;
  localparam int POS_W   = sci_pkg::POS_W;
  localparam int DER_W   = sci_pkg::DER_W;
  localparam int TIME_W  = sci_pkg::TIME_W;
  localparam int COUNT_W = sci_pkg::COUNT_W;
  localparam int RATE_W  = sci_pkg::RATE_W;
  localparam int OP_W    = DER_W + 2;
  localparam int PROD_W  = OP_W + RATE_W + 1;
  localparam int LANES   = 3;

  localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) <<< (DER_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) <<< (DER_W - 1));

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_EMUL  = 15'h0002,
    S_EIDX  = 15'h0004,
    S_ERA   = 15'h0008,
    S_ERB   = 15'h0010,
    S_ECAP  = 15'h0020,
    S_LSUB  = 15'h0040,
    S_LMUL  = 15'h0080,
    S_LADD  = 15'h0100,
    S_EDONE = 15'h0200,
    S_DLO   = 15'h0400,
    S_DHI   = 15'h0800,
    S_DSUB  = 15'h1000,
    S_DMUL  = 15'h2000,
    S_DWR   = 15'h4000
  } state_t;

  // Scale a product down by one or two (toward zero) and clamp to 48 bits
  function automatic logic signed [DER_W-1:0] sat_scale(input logic signed [PROD_W-1:0] p,
                                                        input logic halve);
    logic signed [PROD_W-1:0] q;
    begin
      q = halve ? ((p + $signed({{(PROD_W-1){1'b0}}, p[PROD_W-1]})) >>> 1) : p;
      if (q > SAT_HI) begin
        sat_scale = SAT_HI[DER_W-1:0];
      end else if (q < SAT_LO) begin
        sat_scale = SAT_LO[DER_W-1:0];
      end else begin
        sat_scale = q[DER_W-1:0];
      end
    end
  endfunction

  state_t                   state_r, state_nxt;
  logic                     out_valid_r;
  logic [COUNT_W-1:0]       count_r;
  logic [RATE_W-1:0]        rate_r;
  logic [ADDR_W-1:0]        i_r;
  logic                     phase_r;
  logic [1:0]               lane_r;

  logic signed [OP_W-1:0]   mul_a_r;
  logic [RATE_W-1:0]        mul_b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] mul_out;
  logic [ADDR_W-1:0]        ia_r, ib_r;
  logic [FRAC-1:0]          frac_r;
  logic signed [OP_W-1:0]   pa_r [LANES];
  logic signed [OP_W-1:0]   pb_r [LANES];
  logic signed [DER_W-1:0]  res_r [LANES];
  logic signed [OP_W-1:0]   lo_r;
  sci_pkg::out_item_t       out_data_r;

  logic [POS_W-1:0]         pos_mem [sci_pkg::TABLE_DEPTH];
  logic [DER_W-1:0]         slp_mem [sci_pkg::TABLE_DEPTH];
  logic [DER_W-1:0]         acc_mem [sci_pkg::TABLE_DEPTH];
  logic [POS_W-1:0]         pos_rd_r;
  logic [DER_W-1:0]         slp_rd_r;
  logic [DER_W-1:0]         acc_rd_r;

  logic                     in_acc;
  logic                     out_load;
  logic [COUNT_W-1:0]       n_used;
  logic [COUNT_W-1:0]       last_full;
  logic [ADDR_W-1:0]        last_idx;
  logic [RATE_W-1:0]        rate_used;
  logic                     at_first, at_last;
  logic [ADDR_W-1:0]        lo_idx, hi_idx;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [OP_W-1:0]   src_rd;
  logic signed [DER_W-1:0]  der_wr;
  logic [TIME_W-1:0]        whole;
  logic signed [PROD_W-1:0] lane_sum;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_EDONE) && (!out_valid_r || !out_stall);

  // Effective sample count and rate
  always_comb begin
    if (count_r < COUNT_W'(2)) begin
      n_used = COUNT_W'(2);
    end else if (count_r > COUNT_W'(sci_pkg::TABLE_DEPTH)) begin
      n_used = COUNT_W'(sci_pkg::TABLE_DEPTH);
    end else begin
      n_used = count_r;
    end
    last_full = n_used - COUNT_W'(1);
    last_idx  = last_full[ADDR_W-1:0];
    rate_used = (rate_r == '0) ? RATE_W'(1) : rate_r;
  end

  // Neighbor indexes for the derivative pass
  always_comb begin
    at_first = (i_r == '0);
    at_last  = (i_r == last_idx);
    lo_idx   = at_first ? '0 : i_r - ADDR_W'(1);
    hi_idx   = at_last ? i_r : i_r + ADDR_W'(1);
  end

  // Shared multiplier
  assign mul_out = PROD_W'(mul_a_r) * PROD_W'($signed({1'b0, mul_b_r}));

  // Derivative source and scaled result
  assign src_rd   = phase_r ? OP_W'($signed(slp_rd_r)) : OP_W'($signed(pos_rd_r));
  assign der_wr   = sat_scale(prod_r, !(at_first || at_last));
  assign whole    = prod_r[FRAC+TIME_W-1:FRAC];
  assign lane_sum = PROD_W'(pa_r[lane_r]) + (prod_r >>> FRAC);

  // Select the table read address
  always_comb begin
    unique case (state_r)
      S_ERA:   rd_addr = ia_r;
      S_ERB:   rd_addr = ib_r;
      S_DLO:   rd_addr = lo_idx;
      S_DHI:   rd_addr = hi_idx;
      default: rd_addr = ia_r;
    endcase
  end

  // Tables: one write and one registered read each
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.cmd == sci_pkg::CMD_LOAD)) begin
      pos_mem[in_data.sample_index[ADDR_W-1:0]] <= in_data.sample_value;
    end
    pos_rd_r <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DWR) && !phase_r) begin
      slp_mem[i_r] <= der_wr;
    end
    slp_rd_r <= slp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DWR) && phase_r) begin
      acc_mem[i_r] <= der_wr;
    end
    acc_rd_r <= acc_mem[rd_addr];
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == sci_pkg::CMD_EVAL) begin
            state_nxt = S_EMUL;
          end else if (in_data.last_sample) begin
            state_nxt = S_DLO;
          end
        end
      end
      S_EMUL:  state_nxt = S_EIDX;
      S_EIDX:  state_nxt = S_ERA;
      S_ERA:   state_nxt = S_ERB;
      S_ERB:   state_nxt = S_ECAP;
      S_ECAP:  state_nxt = S_LSUB;
      S_LSUB:  state_nxt = S_LMUL;
      S_LMUL:  state_nxt = S_LADD;
      S_LADD:  state_nxt = (lane_r == 2'(LANES - 1)) ? S_EDONE : S_LSUB;
      S_EDONE: state_nxt = out_load ? S_IDLE : S_EDONE;
      S_DLO:   state_nxt = S_DHI;
      S_DHI:   state_nxt = S_DSUB;
      S_DSUB:  state_nxt = S_DMUL;
      S_DMUL:  state_nxt = S_DWR;
      S_DWR:   state_nxt = (at_last && phase_r) ? S_IDLE : S_DLO;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= sci_pkg::COUNT_RESET;
      rate_r      <= sci_pkg::RATE_RESET;
      i_r         <= '0;
      phase_r     <= 1'b0;
      lane_r      <= '0;
    end else begin
      state_r <= state_nxt;

      // Hold the result until taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (sci_pkg::cfg_reg_t'(cfg_index))
          sci_pkg::CFG_SAMPLE_COUNT: count_r <= cfg_data[COUNT_W-1:0];
          sci_pkg::CFG_SAMPLE_RATE:  rate_r  <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end

      // Start a derivative pass
      if (in_acc && (in_data.cmd == sci_pkg::CMD_LOAD) && in_data.last_sample) begin
        i_r     <= '0;
        phase_r <= 1'b0;
      end

      // Advance through the table
      if (state_r == S_DWR) begin
        if (at_last) begin
          i_r     <= '0;
          phase_r <= 1'b1;
        end else begin
          i_r <= i_r + ADDR_W'(1);
        end
      end

      // Advance through the interpolation lanes
      if (state_r == S_ECAP) begin
        lane_r <= '0;
      end else if (state_r == S_LADD) begin
        lane_r <= lane_r + 2'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        mul_a_r <= {{(OP_W-TIME_W){1'b0}}, in_data.query_time};
        mul_b_r <= rate_used;
      end
      S_EMUL, S_LMUL, S_DMUL: begin
        prod_r <= mul_out;
      end
      S_EIDX: begin
        if (whole >= TIME_W'(last_idx)) begin
          ia_r   <= last_idx;
          ib_r   <= last_idx;
          frac_r <= '0;
        end else begin
          ia_r   <= whole[ADDR_W-1:0];
          ib_r   <= whole[ADDR_W-1:0] + ADDR_W'(1);
          frac_r <= prod_r[FRAC-1:0];
        end
      end
      S_ERB: begin
        pa_r[0] <= OP_W'($signed(pos_rd_r));
        pa_r[1] <= OP_W'($signed(slp_rd_r));
        pa_r[2] <= OP_W'($signed(acc_rd_r));
      end
      S_ECAP: begin
        pb_r[0] <= OP_W'($signed(pos_rd_r));
        pb_r[1] <= OP_W'($signed(slp_rd_r));
        pb_r[2] <= OP_W'($signed(acc_rd_r));
      end
      S_LSUB: begin
        mul_a_r <= pb_r[lane_r] - pa_r[lane_r];
        mul_b_r <= frac_r;
      end
      S_LADD: begin
        res_r[lane_r] <= lane_sum[DER_W-1:0];
      end
      S_DHI: begin
        lo_r <= src_rd;
      end
      S_DSUB: begin
        mul_a_r <= src_rd - lo_r;
        mul_b_r <= rate_used;
      end
      default: ;
    endcase

    // Drop the finished result into the output register
    if (out_load) begin
      out_data_r.value        <= res_r[0][POS_W-1:0];
      out_data_r.slope        <= res_r[1];
      out_data_r.acceleration <= res_r[2];
    end
  end

endmodule

`default_nettype wire
